// ===== rtl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Word types, command and status groups and fixed field widths shared by the
// cache controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CAP_W      = 5;
  localparam int CAP_RESET  = 16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic                         func;
    logic [KEY_BITS-1:0]          lookup_key;
    logic signed [VALUE_BITS-1:0] store_value;
  } in_word_t;

  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
    logic respond;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_put;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/lkv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address shared by write and read; the read data is registered and
// holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/lkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences one word at a time through compare, update and, for a get only,
// respond, and owns the input stall and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire lkv_pkg::status_t status,
  output lkv_pkg::cmd_t         cmd
);

  import lkv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The output register can take a new word when empty or drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = status.is_put ? S_IDLE : S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.respond   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/lkv_dp.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// A row of slot cells (key, valid, recency rank) compared in parallel, the
// value RAM, the capacity register and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_dp #(
  parameter int ENTRIES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lkv_pkg::cmd_t             cmd,
  output lkv_pkg::status_t               status,
  input  wire lkv_pkg::in_word_t         in_word,
  input  wire logic                      cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
  output lkv_pkg::out_word_t             out_word
);

  import lkv_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CW     = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  in_word_t            item_r;
  logic [KEY_BITS-1:0] keys_r [ENTRIES];
  logic [RANK_W-1:0]   rank_r [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  logic [OCC_W-1:0]    occ_r;
  logic [CAP_W-1:0]    cap_r;

  logic [ENTRIES-1:0]  match_r, evict_r, free_r;
  logic                hit_r, full_r;
  out_word_t           out_r;

  logic [ENTRIES-1:0]    match_c, evict_c, free_c;
  logic [CW-1:0]         cap_ext, eff_cap;
  logic [ENTRIES-1:0]    sel;
  logic [IDX_W-1:0]      sel_idx;
  logic [RANK_W-1:0]     hit_rank;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  put_miss;

  // Capacity zero acts as one; capacity beyond the slot count acts as full size.
  assign cap_ext = CW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Ranks of valid slots always form 0 .. occupancy-1, so the least recent
  // slot is the one whose rank equals occupancy-1.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_c[i] = valid_r[i] && (keys_r[i] == item_r.lookup_key);
      evict_c[i] = valid_r[i] && (OCC_W'(rank_r[i]) == (occ_r - OCC_W'(1)));
    end
  end

  // Lowest free slot as a one-hot word.
  assign free_c = ~valid_r & (valid_r + ENTRIES'(1));

  assign sel      = hit_r ? match_r : (full_r ? evict_r : free_r);
  assign put_miss = item_r.func && !hit_r;

  always_comb begin
    sel_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
      end
      if (match_r[i]) begin
        hit_rank = hit_rank | rank_r[i];
      end
    end
  end

  lkv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_value_ram (
    .clk   (clk),
    .we    (cmd.update && item_r.func),
    .re    (cmd.update && !item_r.func && hit_r),
    .addr  (sel_idx),
    .wdata (item_r.store_value),
    .rdata (ram_rdata)
  );

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_word;
    end
    if (cmd.compare) begin
      match_r <= match_c;
      evict_r <= evict_c;
      free_r  <= free_c;
      hit_r   <= |match_c;
      full_r  <= (CW'(occ_r) >= eff_cap);
    end
    if (cmd.update && put_miss) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i]) begin
          keys_r[i] <= item_r.lookup_key;
        end
      end
    end
    if (cmd.respond) begin
      out_r.hit        <= hit_r;
      out_r.read_value <= hit_r ? ram_rdata : '1;
    end
  end

  // Control state: occupancy, valid bits, ranks and capacity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= CAP_W'(CAP_RESET);
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.update) begin
        if (hit_r) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (match_r[i]) begin
              rank_r[i] <= '0;
            end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
              rank_r[i] <= rank_r[i] + RANK_W'(1);
            end
          end
        end else if (item_r.func) begin
          // The evicted or free slot takes the new key as most recent.
          for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
              rank_r[i]  <= '0;
              valid_r[i] <= 1'b1;
            end else if (valid_r[i]) begin
              rank_r[i] <= rank_r[i] + RANK_W'(1);
            end
          end
          if (!full_r) begin
            occ_r <= occ_r + OCC_W'(1);
          end
        end
      end
    end
  end

  assign status.is_put = item_r.func;
  assign out_word      = out_r;

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache unit
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each input word is a get or a put. A get returns one output word: hit set
// with the stored value, or hit clear with read_value all ones; it makes the
// entry found the most recent. A put stores or replaces a value, evicting the
// least recent entry when the store holds capacity entries, and returns
// nothing. Words are handled one at a time: a put passes through acceptance,
// a compare across the slot row and an update; a get also reads the value
// RAM in its update, then waits to load the output register for as long as
// that register is still stalled with the previous result. A new word is
// accepted while a finished result waits to be taken.
// The capacity register (reset 16) is written with cfg_we and should only
// change while the unit is idle; zero acts as one and values above ENTRIES
// act as ENTRIES.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire lkv_pkg::in_word_t         in_word,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output lkv_pkg::out_word_t             out_word,
  input  wire logic                      cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);

  import lkv_pkg::*;

  cmd_t    cmd;
  status_t status;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lkv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache unit testbench
// Sends get and put words through the cache while the capacity register steps
// through small, large and out-of-range settings, and checks every get result
// against a recency-ordered model of the store kept alongside the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  import lkv_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int HALF_PERIOD  = 5;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 153;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we    = 1'b0;
  logic [CAP_W-1:0]     cfg_wdata = '0;

  // Cache model: slot contents, recency age (0 is most recent) and occupancy.
  logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
  logic [VALUE_BITS-1:0] slot_value [ENTRIES];
  bit                    slot_used  [ENTRIES] = '{default: 1'b0};
  int                    slot_age   [ENTRIES] = '{default: 0};
  int                    used_slots  = 0;
  int                    cap_setting = CAP_RESET;

  in_word_t  pending_words [$];
  out_word_t results_due   [$];

  bit word_taken      = 1'b0;
  int error_count     = 0;
  int words_accepted  = 0;
  int results_checked = 0;
  int hits_checked    = 0;
  int evictions       = 0;
  int settings_used   = 0;

  lru_key_value_cache_unit #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void promote(input int s);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Applies one accepted word to the model and queues the result a get owes.
  function automatic void cache_apply(input in_word_t w);
    int        i;
    int        found;
    int        oldest;
    int        room;
    out_word_t r;
    found = -1;
    for (i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_key[i] == w.lookup_key) found = i;
    if (w.func == FUNC_GET) begin
      if (found >= 0) begin
        promote(found);
        r.hit        = 1'b1;
        r.read_value = slot_value[found];
      end else begin
        r.hit        = 1'b0;
        r.read_value = '1;
      end
      results_due.push_back(r);
      return;
    end
    if (found >= 0) begin
      slot_value[found] = w.store_value;
      promote(found);
      return;
    end
    room = (cap_setting == 0) ? 1 : ((cap_setting > ENTRIES) ? ENTRIES : cap_setting);
    // A new key into a store at or above capacity drops exactly one entry,
    // even when capacity was lowered below the current occupancy.
    if (used_slots >= room) begin
      oldest = -1;
      for (i = 0; i < ENTRIES; i++)
        if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
      slot_used[oldest] = 1'b0;
      slot_age[oldest]  = 0;
      used_slots--;
      evictions++;
    end
    for (i = 0; i < ENTRIES; i++)
      if (slot_used[i]) slot_age[i]++;
    found = -1;
    for (i = ENTRIES - 1; i >= 0; i--)
      if (!slot_used[i]) found = i;
    slot_key[found]   = w.lookup_key;
    slot_value[found] = w.store_value;
    slot_used[found]  = 1'b1;
    slot_age[found]   = 0;
    used_slots++;
  endfunction

  // Monitor: model updates on accepted words and register writes, and result
  // checks, all at the rising edge.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      word_taken <= in_valid && !in_stall;
      if (cfg_we) cap_setting = int'(cfg_wdata);
      if (in_valid && !in_stall) begin
        cache_apply(in_word);
        words_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result word with no get outstanding: hit %0b value %0h",
                 out_word.hit, out_word.read_value);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (out_word.hit !== want.hit) begin
            $error("hit mismatch: expected %0b, got %0b", want.hit, out_word.hit);
            error_count++;
          end
          if (out_word.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0h, got %0h",
                   want.read_value, out_word.read_value);
            error_count++;
          end
          results_checked++;
          if (want.hit) hits_checked++;
        end
      end
    end
  end

  // Driver: bursts of words separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // Word still on offer; hold it.
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_words.size() > 0) begin
      in_word  <= pending_words.pop_front();
      in_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus long
  // hold-offs that back the unit up into its input.
  int stall_tick   = 0;
  int stall_mode   = 0;
  int hold_left    = 0;
  int next_hold_at = 60;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left == 0 && results_checked >= next_hold_at) begin
        hold_left    = HOLD_CYCLES;
        next_hold_at = next_hold_at + 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        unique case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic queue_word(input logic f, input logic [KEY_BITS-1:0] k,
                            input logic [VALUE_BITS-1:0] v);
    pending_words.push_back(in_word_t'{func: f, lookup_key: k, store_value: v});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || results_due.size() != 0);
    // A trailing put produces no result but may still be updating the slots.
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    @(negedge clk);
    cfg_wdata <= c;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    unique case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Gets and puts over a small key pool so hits, updates and evictions all
  // occur; a few words use fresh random keys.
  task automatic random_phase(input int pool_n, input int n_words);
    logic [KEY_BITS-1:0] pool [32];
    logic [KEY_BITS-1:0] k;
    int                  put_pct;
    int                  i;
    for (i = 0; i < pool_n; i++) pool[i] = $urandom;
    if ($urandom_range(0, 2) == 0) pool[0] = '0;
    if ($urandom_range(0, 2) == 0) pool[pool_n - 1] = '1;
    put_pct = $urandom_range(25, 60);
    for (i = 0; i < n_words; i++) begin
      k = ($urandom_range(0, 99) < 12) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
      if ($urandom_range(0, 99) < put_pct) queue_word(FUNC_PUT, k, pick_value());
      else queue_word(FUNC_GET, k, $urandom);
    end
  endtask

  initial begin
    int caps  [PHASES];
    int pools [PHASES];
    int p;
    caps  = '{31, 16, 1, 7, 0, 2, 12, 4, 16, 9};
    pools = '{24, 20, 3, 10, 2, 5, 16, 8, 22, 12};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity: miss on an empty store, extreme keys and values, and
    // an update that stores all ones, which must still read back as a hit.
    queue_word(FUNC_GET, 32'h0000_0000, 32'h1234_5678);
    queue_word(FUNC_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    queue_word(FUNC_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_word(FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_word(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_word(FUNC_GET, 32'h0000_0000, 32'h5A5A_A5A5);
    queue_word(FUNC_GET, 32'h0000_0005, 32'hA5A5_5A5A);
    wait_drained();

    // Capacity zero behaves as one, and it sits below the current occupancy:
    // each new key evicts a single entry.
    set_capacity(0);
    queue_word(FUNC_PUT, 32'hAAAA_5555, 32'h0000_0001);
    queue_word(FUNC_PUT, 32'h5555_AAAA, 32'h0000_0002);
    queue_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    queue_word(FUNC_GET, 32'hAAAA_5555, 32'h0000_0000);
    queue_word(FUNC_GET, 32'h5555_AAAA, 32'h0000_0000);
    queue_word(FUNC_PUT, 32'h5555_AAAA, 32'h8000_0000);
    queue_word(FUNC_GET, 32'h5555_AAAA, 32'hFFFF_FFFF);
    wait_drained();

    // Small capacity: a get refreshes recency, so the next eviction skips it.
    set_capacity(3);
    queue_word(FUNC_PUT, 32'h0000_0001, 32'h1111_1111);
    queue_word(FUNC_PUT, 32'h8000_0000, 32'h2222_2222);
    queue_word(FUNC_PUT, 32'hFFFF_FFFE, 32'h3333_3333);
    queue_word(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
    queue_word(FUNC_PUT, 32'h7FFF_FFFF, 32'h4444_4444);
    queue_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    queue_word(FUNC_GET, 32'hFFFF_FFFE, 32'h0000_0000);
    queue_word(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      set_capacity(CAP_W'(caps[p]));
      random_phase(pools[p], PHASE_WORDS);
      wait_drained();
    end

    $display("Sent %0d words across %0d capacity settings with %0d evictions.",
             words_accepted, settings_used, evictions);
    $display("Checked %0d get results, %0d of them hits.", results_checked, hits_checked);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d words pending and %0d results outstanding.",
             pending_words.size(), results_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
